FILE: rtl/nwc_pkg.sv
// Shared types and constants for the 2D network coordinate update block.
// Used by the shared root/divide unit and by the top level sequencer.
`default_nettype none
package nwc_pkg;

  localparam int unsigned RemW   = 36;  // partial remainder of the root/divide unit
  localparam int unsigned ShW    = 64;  // operand shift register of the unit
  localparam int unsigned DenW   = 34;  // divisor width
  localparam int unsigned ResW   = 37;  // widest quotient (relative error)
  localparam int unsigned CountW = 6;   // iteration counter

  localparam logic [31:0] LfsrSeed = 32'hACE1_2468;
  localparam logic [31:0] LfsrMask = 32'h8020_0003;

  localparam logic [15:0] GainMoveRst  = 16'd16384;
  localparam logic [15:0] GainErrorRst = 16'd16384;
  localparam logic [15:0] WeightUnRst  = 16'd6554;
  localparam logic [15:0] MaxRatioRst  = 16'd32768;

  typedef enum logic [1:0] {
    CFG_GAIN_MOVE  = 2'd0,
    CFG_GAIN_ERROR = 2'd1,
    CFG_WEIGHT_UN  = 2'd2,
    CFG_MAX_RATIO  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic              start;
    logic              is_sqrt;
    logic [CountW-1:0] count;
  } iter_req_t;

  typedef struct packed {
    logic            done;
    logic [ResW-1:0] res;
  } iter_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/network_coordinate_update.sv
// Samples are handled one at a time. The shared root/divide unit resolves one
// result bit per cycle. Every sample runs a 32-step root and, when both errors
// are set, a 16-step weight division. An accepted move adds two 17-step unit
// vector divisions and, once the error is set, a 37-step relative error
// division. A same-position sample adds a second 32-step root. The remaining
// steps share one 33x32 multiplier. in_stall_o is high from the accepted input
// transaction until its result transaction completes.
// Depends on nwc_pkg and nwc_iter.
`default_nettype none
module network_coordinate_update import nwc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] remote_x_i,
  input  logic signed [31:0] remote_y_i,
  input  logic signed [31:0] remote_error_i,
  input  logic [19:0]        measured_rtt_i,
  input  logic               force_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               moved_o,
  output logic signed [31:0] own_x_o,
  output logic signed [31:0] own_y_o,
  output logic [31:0]        own_error_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001, S_SQA   = 20'h00002, S_SQB  = 20'h00004,
    S_ROOT  = 20'h00008, S_WGT   = 20'h00010, S_DELTA = 20'h00020,
    S_MOVE  = 20'h00040, S_RATIO = 20'h00080, S_RND  = 20'h00100,
    S_UX    = 20'h00200, S_UY    = 20'h00400, S_STX  = 20'h00800,
    S_STY   = 20'h01000, S_REL   = 20'h02000, S_EW   = 20'h04000,
    S_E1    = 20'h08000, S_E2    = 20'h10000, S_E3   = 20'h20000,
    S_E4    = 20'h40000, S_OUT   = 20'h80000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] gm_q, ge_q, wu_q, mr_q;
  logic [31:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d, err_q, err_d, lfsr_q, lfsr_d;
  logic        moved_q, moved_d, pend_q, pend_d, phase_q, phase_d;

  // Sample and intermediate values.
  logic [32:0] dx_q, dy_q, dist_q, len_q, move_mag_q;
  logic [31:0] rerr_q;
  logic [19:0] rtt_q;
  logic        force_q, move_neg_q;
  logic [16:0] w_q, ux_q, uy_q;
  logic [15:0] delta_q, ew_q;
  logic [36:0] rel_q;
  logic [63:0] acc_q;

  logic [31:0] uax, uay;
  logic [30:0] ua_s, ub_s;
  logic        shr;
  logic [31:0] rq;
  logic        diff_neg, rerr_pos, accept;
  logic [32:0] aerr;
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod;
  logic [31:0] lfsr_nxt;
  logic        step_neg;
  logic [35:0] step_sum;

  iter_req_t       ireq;
  iter_rsp_t       irsp;
  logic [RemW-1:0] irem;
  logic [ShW-1:0]  ish;
  logic [DenW-1:0] iden;

  function automatic logic [31:0] sat_s36(input logic [35:0] v);
    if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
      return v[31:0];
    end else if (v[35]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

  function automatic logic [35:0] step_pos(input logic [31:0] p, input logic [33:0] s,
                                           input logic neg);
    logic [35:0] pe, se;
    pe = {{4{p[31]}}, p};
    se = {2'b00, s};
    return neg ? (pe - se) : (pe + se);
  endfunction

  // Magnitudes of the difference vector; both halve when either is too wide.
  assign uax  = dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
  assign uay  = dy_q[32] ? 32'(-dy_q) : dy_q[31:0];
  assign shr  = uax[31] | uay[31];
  assign ua_s = shr ? uax[31:1] : uax[30:0];
  assign ub_s = shr ? uay[31:1] : uay[30:0];

  assign rq       = {rtt_q, 12'd0};
  assign diff_neg = dist_q > {1'b0, rq};
  assign aerr     = diff_neg ? (dist_q - {1'b0, rq}) : ({1'b0, rq} - dist_q);
  assign rerr_pos = !rerr_q[31] && (rerr_q != '0);
  assign lfsr_nxt = {1'b0, lfsr_q[31:1]} ^ (lfsr_q[0] ? LfsrMask : 32'd0);
  assign step_neg = ((state_q == S_STX) ? dx_q[32] : dy_q[32]) ^ move_neg_q;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SQA:   begin mul_a = {2'b00, ua_s}; mul_b = {1'b0, ua_s}; end
      S_SQB:   begin mul_a = {2'b00, ub_s}; mul_b = {1'b0, ub_s}; end
      S_DELTA: begin mul_a = 33'(w_q);  mul_b = 32'(gm_q); end
      S_MOVE:  begin mul_a = aerr;      mul_b = 32'(delta_q); end
      S_RATIO: begin mul_a = dist_q;    mul_b = 32'(mr_q); end
      S_STX:   begin mul_a = move_mag_q; mul_b = 32'(ux_q); end
      S_STY:   begin mul_a = move_mag_q; mul_b = 32'(uy_q); end
      S_EW:    begin mul_a = 33'(w_q);  mul_b = 32'(ge_q); end
      S_E1:    begin mul_a = 33'(rel_q[31:0]);  mul_b = 32'(ew_q); end
      S_E2:    begin mul_a = 33'(rel_q[36:32]); mul_b = 32'(ew_q); end
      S_E3:    begin mul_a = 33'(err_q); mul_b = 32'(17'h10000 - 17'(ew_q)); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod   = 65'(mul_a) * 65'(mul_b);
  assign accept = force_q || (dist_q == '0) || move_neg_q ||
                  ({move_mag_q, 16'd0} < prod[48:0]);

  assign step_sum = step_pos((state_q == S_STX) ? pos_x_q : pos_y_q, prod[49:16], step_neg);

  // Operands for the root/divide unit.
  always_comb begin
    ireq.start   = 1'b0;
    ireq.is_sqrt = 1'b0;
    ireq.count   = '0;
    irem         = '0;
    ish          = '0;
    iden         = '0;
    unique case (state_q)
      S_ROOT: begin
        ireq.start   = !pend_q;
        ireq.is_sqrt = 1'b1;
        ireq.count   = CountW'(32);
        ish          = acc_q;
      end
      S_WGT: begin
        ireq.start = !pend_q && (err_q != '0) && rerr_pos;
        ireq.count = CountW'(16);
        irem       = RemW'(err_q);
        iden       = DenW'(err_q) + DenW'(rerr_q);
      end
      S_UX, S_UY: begin
        ireq.start = !pend_q;
        ireq.count = CountW'(17);
        irem       = RemW'((state_q == S_UX) ? uax[31:1] : uay[31:1]);
        ish        = {((state_q == S_UX) ? uax[0] : uay[0]), 63'd0};
        iden       = DenW'(len_q);
      end
      S_REL: begin
        ireq.start = !pend_q;
        ireq.count = CountW'(37);
        ish        = {aerr, 4'd0, 27'd0};
        iden       = DenW'(rtt_q);
      end
      default: begin
        ireq.start = 1'b0;
      end
    endcase
  end

  nwc_iter u_iter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ireq),
    .rem_init_i(irem),
    .sh_init_i (ish),
    .den_i     (iden),
    .rsp_o     (irsp)
  );

  // Sequencer and architectural state.
  always_comb begin
    state_d = state_q;
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    err_d   = err_q;
    lfsr_d  = lfsr_q;
    moved_d = moved_q;
    pend_d  = pend_q;
    phase_d = phase_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          phase_d = 1'b0;
          state_d = S_SQA;
        end
      end
      S_SQA: state_d = S_SQB;
      S_SQB: state_d = S_ROOT;
      S_ROOT: begin
        pend_d = 1'b1;
        if (irsp.done) begin
          pend_d = 1'b0;
          if (!phase_q) begin
            state_d = S_WGT;
          end else if (irsp.res[31:0] == '0) begin
            // Random direction of zero length: nothing moves.
            state_d = S_OUT;
          end else begin
            state_d = S_UX;
          end
        end
      end
      S_WGT: begin
        if ((err_q == '0) || !rerr_pos) begin
          state_d = S_DELTA;
        end else begin
          pend_d = 1'b1;
          if (irsp.done) begin
            pend_d  = 1'b0;
            state_d = S_DELTA;
          end
        end
      end
      S_DELTA: state_d = S_MOVE;
      S_MOVE:  state_d = S_RATIO;
      S_RATIO: begin
        moved_d = accept;
        if (!accept) begin
          state_d = S_OUT;
        end else if (dist_q == '0) begin
          state_d = S_RND;
        end else begin
          state_d = S_UX;
        end
      end
      S_RND: begin
        lfsr_d  = lfsr_nxt;
        phase_d = 1'b1;
        state_d = S_SQA;
      end
      S_UX, S_UY, S_REL: begin
        pend_d = 1'b1;
        if (irsp.done) begin
          pend_d = 1'b0;
          unique case (state_q)
            S_UX:    state_d = S_UY;
            S_UY:    state_d = S_STX;
            default: state_d = S_EW;
          endcase
        end
      end
      S_STX: begin
        pos_x_d = sat_s36(step_sum);
        state_d = S_STY;
      end
      S_STY: begin
        pos_y_d = sat_s36(step_sum);
        if (err_q == '0) begin
          err_d   = (aerr[32:28] != '0) ? 32'hFFFF_FFFF : {aerr[27:0], 4'd0};
          state_d = S_OUT;
        end else begin
          state_d = S_REL;
        end
      end
      S_EW: state_d = S_E1;
      S_E1: state_d = S_E2;
      S_E2: state_d = S_E3;
      S_E3: state_d = S_E4;
      S_E4: begin
        err_d   = (acc_q[63:48] != '0) ? 32'hFFFF_FFFF : acc_q[47:16];
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_x_q <= '0;
      pos_y_q <= '0;
      err_q   <= '0;
      lfsr_q  <= LfsrSeed;
      moved_q <= 1'b0;
      pend_q  <= 1'b0;
      phase_q <= 1'b0;
      gm_q    <= GainMoveRst;
      ge_q    <= GainErrorRst;
      wu_q    <= WeightUnRst;
      mr_q    <= MaxRatioRst;
    end else begin
      state_q <= state_d;
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      err_q   <= err_d;
      lfsr_q  <= lfsr_d;
      moved_q <= moved_d;
      pend_q  <= pend_d;
      phase_q <= phase_d;
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_GAIN_MOVE:  gm_q <= cfg_data_i;
          CFG_GAIN_ERROR: ge_q <= cfg_data_i;
          CFG_WEIGHT_UN:  wu_q <= cfg_data_i;
          CFG_MAX_RATIO:  mr_q <= cfg_data_i;
          default:        gm_q <= gm_q;
        endcase
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          dx_q    <= {pos_x_q[31], pos_x_q} - {remote_x_i[31], remote_x_i};
          dy_q    <= {pos_y_q[31], pos_y_q} - {remote_y_i[31], remote_y_i};
          rerr_q  <= remote_error_i;
          rtt_q   <= (measured_rtt_i == '0) ? 20'd1 : measured_rtt_i;
          force_q <= force_req_i;
        end
      end
      S_SQA: acc_q <= prod[63:0];
      S_SQB: acc_q <= acc_q + prod[63:0];
      S_ROOT: begin
        if (irsp.done) begin
          len_q <= phase_q ? {1'b0, irsp.res[31:0]}
                           : (shr ? {irsp.res[31:0], 1'b0} : {1'b0, irsp.res[31:0]});
          if (!phase_q) begin
            dist_q <= shr ? {irsp.res[31:0], 1'b0} : {1'b0, irsp.res[31:0]};
          end
        end
      end
      S_WGT: begin
        if (err_q == '0) begin
          w_q <= 17'h10000;
        end else if (!rerr_pos) begin
          w_q <= 17'(wu_q);
        end else if (irsp.done) begin
          w_q <= irsp.res[16:0];
        end
      end
      S_DELTA: delta_q <= prod[31:16];
      S_MOVE: begin
        move_mag_q <= prod[48:16];
        move_neg_q <= diff_neg && (prod[48:16] != '0);
      end
      S_RND: begin
        dx_q <= {{17{lfsr_nxt[15]}}, lfsr_nxt[15:0]};
        dy_q <= {{17{lfsr_nxt[31]}}, lfsr_nxt[31:16]};
      end
      S_UX:  if (irsp.done) ux_q <= irsp.res[16:0];
      S_UY:  if (irsp.done) uy_q <= irsp.res[16:0];
      S_REL: if (irsp.done) rel_q <= irsp.res;
      S_EW:  ew_q  <= prod[31:16];
      S_E1:  acc_q <= prod[63:0];
      S_E2:  acc_q <= acc_q + {prod[31:0], 32'd0};
      S_E3:  acc_q <= acc_q + prod[63:0];
      default: acc_q <= acc_q;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign moved_o     = moved_q;
  assign own_x_o     = pos_x_q;
  assign own_y_o     = pos_y_q;
  assign own_error_o = err_q;
  assign cfg_ready_o = 1'b1;

endmodule
`default_nettype wire

FILE: rtl/nwc_iter.sv
// Shared iterative unit: restoring square root (two operand bits per step)
// and restoring division (one quotient bit per step). Depends on nwc_pkg.
`default_nettype none
module nwc_iter import nwc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  iter_req_t       req_i,
  input  logic [RemW-1:0] rem_init_i,
  input  logic [ShW-1:0]  sh_init_i,
  input  logic [DenW-1:0] den_i,
  output iter_rsp_t       rsp_o
);

  logic [RemW-1:0]   rem_q, rem_d, trial, sub;
  logic [ShW-1:0]    sh_q, sh_d;
  logic [ResW-1:0]   res_q, res_d;
  logic [DenW-1:0]   den_q;
  logic              sqrt_q, busy_q, done_q, ge;
  logic [CountW-1:0] cnt_q;

  always_comb begin
    if (sqrt_q) begin
      trial = {rem_q[RemW-3:0], sh_q[ShW-1 -: 2]};
      sub   = {res_q[RemW-3:0], 2'b01};
      sh_d  = {sh_q[ShW-3:0], 2'b00};
    end else begin
      trial = {rem_q[RemW-2:0], sh_q[ShW-1]};
      sub   = RemW'(den_q);
      sh_d  = {sh_q[ShW-2:0], 1'b0};
    end
    ge    = (trial >= sub);
    rem_d = ge ? (trial - sub) : trial;
    res_d = {res_q[ResW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CountW'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.count;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CountW'(1);
        if (cnt_q == CountW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= rem_init_i;
      sh_q   <= sh_init_i;
      res_q  <= '0;
      den_q  <= den_i;
      sqrt_q <= req_i.is_sqrt;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
      res_q <= res_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule
`default_nettype wire

FILE: rtl/nwc_checker.sv
// Port-level checks for network_coordinate_update, attached by bind.
// Depends only on the top level's ports.
`default_nettype none
module nwc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        moved_o,
  input logic [31:0] own_x_o,
  input logic [31:0] own_y_o,
  input logic [31:0] own_error_o
);

  // A result waiting to be taken holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(own_x_o) &&
      $stable(own_y_o) && $stable(own_error_o) && $stable(moved_o))
    else $error("result changed while stalled");

  // An accepted sample blocks further input.
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a sample is in progress");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a result is pending");

  // A taken result is not repeated.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("result repeated");

endmodule

bind network_coordinate_update nwc_checker u_nwc_checker (.*);
`default_nettype wire

FILE: tb/sv/nwc_update_checker.sv
`timescale 1ns / 1ps
// Checker for network_coordinate_update: watches the sample, result and register
// write channels, predicts each result and compares it. Depends on nwc_pkg.
module nwc_update_checker import nwc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] remote_x_i,
  input  logic signed [31:0] remote_y_i,
  input  logic signed [31:0] remote_error_i,
  input  logic [19:0]        measured_rtt_i,
  input  logic               force_req_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               moved_i,
  input  logic signed [31:0] own_x_i,
  input  logic signed [31:0] own_y_i,
  input  logic [31:0]        own_error_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 rejected_o,
  output logic signed [31:0] coord_x_o,
  output logic signed [31:0] coord_y_o
);

  typedef struct packed {
    logic        moved;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] err;
  } coord_result_t;

  coord_result_t expected_q[$];

  logic [15:0] gain_move, gain_error, weight_un, max_ratio;
  logic [31:0] pos_x, pos_y, loc_err, lfsr;

  assign coord_x_o = pos_x;
  assign coord_y_o = pos_y;
  assign pending_o = expected_q.size();

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Large components are halved before squaring so the sum stays within 64 bits.
  function automatic longint unsigned span(longint a, longint b);
    longint unsigned ua, ub;
    int s;
    ua = mag(a);
    ub = mag(b);
    s = (ua >= 64'h8000_0000 || ub >= 64'h8000_0000) ? 1 : 0;
    ua = ua >> s;
    ub = ub >> s;
    return int_root(ua * ua + ub * ub) << s;
  endfunction

  function automatic longint scale_div(longint num, longint unsigned mul,
                                       longint unsigned den);
    longint unsigned m;
    m = mag(num) * mul / den;
    return num < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic coord_result_t predict_update(logic signed [31:0] rx,
      logic signed [31:0] ry, logic signed [31:0] rerr, logic [19:0] rtt_in,
      logic frc);
    longint px, py, dx, dy, vx, vy, diff, mv, ux, uy, sgn;
    longint unsigned rtt, rq, dist_v, w, delta, aerr, len, ne, rel, ew;
    logic ok;
    coord_result_t r;
    px = longint'(signed'(pos_x));
    py = longint'(signed'(pos_y));
    dx = px - longint'(rx);
    dy = py - longint'(ry);
    rtt = (rtt_in == 0) ? 1 : rtt_in;
    rq = rtt << 12;
    dist_v = span(dx, dy);
    if (loc_err == 0) w = 65536;
    else if (rerr > 0) w = (longint'(loc_err) << 16) / (longint'(loc_err) + longint'(rerr));
    else w = weight_un;
    delta = (longint'(gain_move) * w) >> 16;
    diff = longint'(rq) - longint'(dist_v);
    mv = scale_div(diff, delta, 65536);
    aerr = mag(diff);
    ok = frc || dist_v == 0 || mv < 0 ||
         mag(mv) * 65536 < dist_v * longint'(max_ratio);
    if (ok) begin
      vx = dx;
      vy = dy;
      len = dist_v;
      if (dist_v == 0) begin
        lfsr = lfsr[0] ? ((lfsr >> 1) ^ LfsrMask) : (lfsr >> 1);
        vx = longint'(signed'(lfsr[15:0]));
        vy = longint'(signed'(lfsr[31:16]));
        len = span(vx, vy);
      end
      if (len > 0) begin
        ux = scale_div(vx, 65536, len);
        uy = scale_div(vy, 65536, len);
        sgn = (mv < 0) ? -1 : 1;
        pos_x = clamp32(px + scale_div(ux, mag(mv), 65536) * sgn);
        pos_y = clamp32(py + scale_div(uy, mag(mv), 65536) * sgn);
        if (loc_err == 0) begin
          ne = aerr << 4;
        end else begin
          rel = (aerr << 16) / rq;
          ew = (longint'(gain_error) * w) >> 16;
          ne = (rel * ew + longint'(loc_err) * (65536 - ew)) >> 16;
        end
        loc_err = (ne > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ne[31:0];
      end
    end
    r.moved = ok;
    r.x = pos_x;
    r.y = pos_y;
    r.err = loc_err;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    coord_result_t exp_r;
    if (!rst_ni) begin
      gain_move <= GainMoveRst;
      gain_error <= GainErrorRst;
      weight_un <= WeightUnRst;
      max_ratio <= MaxRatioRst;
      pos_x <= '0;
      pos_y <= '0;
      loc_err <= '0;
      lfsr <= LfsrSeed;
      fail_count_o <= 0;
      checked_o <= 0;
      rejected_o <= 0;
      expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with no sample outstanding");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          checked_o <= checked_o + 1;
          if (!exp_r.moved) rejected_o <= rejected_o + 1;
          if (moved_i !== exp_r.moved || own_x_i !== exp_r.x ||
              own_y_i !== exp_r.y || own_error_i !== exp_r.err) begin
            fail_count_o <= fail_count_o + 1;
            if (moved_i !== exp_r.moved)
              $error("moved: expected %0d, got %0d", exp_r.moved, moved_i);
            if (own_x_i !== exp_r.x)
              $error("own_x: expected %0d, got %0d", $signed(exp_r.x), own_x_i);
            if (own_y_i !== exp_r.y)
              $error("own_y: expected %0d, got %0d", $signed(exp_r.y), own_y_i);
            if (own_error_i !== exp_r.err)
              $error("own_error: expected %0d, got %0d", exp_r.err, own_error_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_GAIN_MOVE:  gain_move <= cfg_data_i;
          CFG_GAIN_ERROR: gain_error <= cfg_data_i;
          CFG_WEIGHT_UN:  weight_un <= cfg_data_i;
          CFG_MAX_RATIO:  max_ratio <= cfg_data_i;
          default: ;
        endcase
      end
      // The prediction updates the coordinate state in place, so blocking
      // updates inside the function are intended here.
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(predict_update(remote_x_i, remote_y_i, remote_error_i,
                                            measured_rtt_i, force_req_i));
    end
  end

endmodule

FILE: tb/sv/tb_network_coordinate_update.sv
`timescale 1ns / 1ps
// Top of the testbench for network_coordinate_update: clock, reset, samples,
// register settings and result-side stalls. Depends on nwc_pkg and nwc_update_checker.
module tb_network_coordinate_update;
  import nwc_pkg::*;

  localparam int PhaseCount = 8;
  localparam int ItemsPerPhase = 220;
  localparam int CycleLimit = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] remote_x_i = '0;
  logic signed [31:0] remote_y_i = '0;
  logic signed [31:0] remote_error_i = '0;
  logic [19:0] measured_rtt_i = '0;
  logic force_req_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic moved_o;
  logic signed [31:0] own_x_o, own_y_o;
  logic [31:0] own_error_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  int fail_count, pending, checked, rejected, cycles;
  logic signed [31:0] coord_x, coord_y;
  bit quiet = 1'b0;
  bit long_hold = 1'b0;

  network_coordinate_update dut (.*);

  nwc_update_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .remote_x_i, .remote_y_i,
    .remote_error_i, .measured_rtt_i, .force_req_i, .out_valid_i(out_valid_o),
    .out_stall_i, .moved_i(moved_o), .own_x_i(own_x_o), .own_y_i(own_y_o),
    .own_error_i(own_error_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked),
    .rejected_o(rejected), .coord_x_o(coord_x), .coord_y_o(coord_y)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result-side stalls: short random bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        out_stall_i <= 1'b0;
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // The extra edge lets the checker record a sample taken at the last edge.
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_sample(logic signed [31:0] rx, logic signed [31:0] ry,
                             logic signed [31:0] rerr, logic [19:0] rtt, logic frc);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    remote_x_i <= rx;
    remote_y_i <= ry;
    remote_error_i <= rerr;
    measured_rtt_i <= rtt;
    force_req_i <= frc;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Mostly nearby remotes with plausible round trips, so moves are accepted and
  // the error gets averaged; the rest are coincident or fully random samples.
  task automatic send_random();
    int kind;
    logic signed [31:0] rx, ry, rerr;
    logic [19:0] rtt;
    kind = $urandom_range(0, 9);
    rerr = $urandom_range(0, 3) == 0 ? -$signed($urandom_range(0, 1 << 20))
                                     : $signed($urandom_range(1, 1 << 18));
    rtt = 20'($urandom_range(0, 400));
    if (kind == 0) begin
      send_sample($urandom, $urandom, $urandom, 20'($urandom),
                  1'($urandom_range(0, 1)));
    end else if (kind == 1) begin
      send_sample(coord_x, coord_y, rerr, rtt, 1'($urandom_range(0, 1)));
    end else begin
      rx = coord_x + ($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      ry = coord_y + ($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      send_sample(rx, ry, rerr, rtt, $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    logic [15:0] gm, ge, wu, mr;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed samples under the reset register values.
    send_sample(0, 0, 0, 0, 1'b0);
    send_sample(coord_x, coord_y, 32'sd65536, 20'd10, 1'b0);
    send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 20'hFFFFF, 1'b0);
    send_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 20'hFFFFF, 1'b1);
    send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1, 20'd1, 1'b0);
    send_sample(coord_x, coord_y, 0, 20'd0, 1'b1);
    send_sample(coord_x + 4096, coord_y, 32'sd4096, 20'd1, 1'b0);
    send_sample(coord_x - 40960, coord_y + 40960, 32'sd0, 20'd500, 1'b0);
    send_sample(coord_x + 409600, coord_y - 409600, -32'sd65536, 20'd1, 1'b0);
    send_sample(coord_x + 409600, coord_y - 409600, 32'sd1, 20'd1, 1'b1);
    send_sample(coord_x, coord_y + 1, 32'sh7FFF_FFFF, 20'd0, 1'b0);
    send_sample(coord_x, coord_y, -32'sd5, 20'd200, 1'b0);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      if (phase > 0) begin
        in_valid_i <= 1'b0;
        wait_drained();
        case (phase)
          1: begin gm = 16'h0000; ge = 16'h0000; wu = 16'h0000; mr = 16'h0000; end
          2: begin gm = 16'hFFFF; ge = 16'hFFFF; wu = 16'hFFFF; mr = 16'hFFFF; end
          7: begin gm = GainMoveRst; ge = GainErrorRst; wu = WeightUnRst; mr = MaxRatioRst; end
          default: begin
            gm = 16'($urandom); ge = 16'($urandom); wu = 16'($urandom); mr = 16'($urandom);
          end
        endcase
        write_reg(CFG_GAIN_MOVE, gm);
        write_reg(CFG_GAIN_ERROR, ge);
        write_reg(CFG_WEIGHT_UN, wu);
        write_reg(CFG_MAX_RATIO, mr);
      end
      quiet = (phase == PhaseCount - 1);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (phase == 2 && n == 50) long_hold = 1'b1;
        if (phase == 4 && n == 60) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        send_random();
      end
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    $display("Checked %0d results over %0d register settings, %0d of them rejected moves.",
             checked, PhaseCount, rejected);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
